@@ hdl/gcs_pkg.sv @@
// Shared types and constants for the greedy circle suppression block.
package gcs_pkg;

  localparam int MAX_CIRCLES = 64;
  localparam int X_W         = 12;
  localparam int Y_W         = 12;
  localparam int R_W         = 11;
  localparam int K_W         = 2;
  localparam int RS_W        = R_W + 1;
  localparam int SQ_W        = 2 * X_W;
  localparam int IDX_W       = $clog2(MAX_CIRCLES);
  localparam int CNT_W       = $clog2(MAX_CIRCLES + 1);
  localparam int CYC_W       = $clog2(MAX_CIRCLES + 2);
  localparam int FIELDS_W    = X_W + Y_W + R_W + K_W;
  localparam int DATA_W      = ((FIELDS_W + 7) / 8) * 8;
  // Cell that receives a circle just as its overlap decision comes out of the tester.
  localparam int KILL_POS    = 2 % MAX_CIRCLES;

  typedef struct packed {
    logic             alive;
    logic [IDX_W-1:0] idx;
    logic [K_W-1:0]   kind;
    logic [R_W-1:0]   r;
    logic [Y_W-1:0]   y;
    logic [X_W-1:0]   x;
  } circle_t;

  typedef struct packed {
    logic shift_en;
    logic clear;
  } cell_ctl_t;

endpackage

@@ hdl/greedy_circle_suppression_top.sv @@
// Greedy circle suppression: ring of circle cells, pipelined overlap test, result register.
// Load one candidate per cycle while in the load state. After the last-marked request
// each round is one pass around the ring plus one hand-over state, so a set with k kept
// circles takes k+1 rounds, longer while the output stalls. The first result is valid
// after the second round, then one per round.
// Reset (rst_n low, synchronous) empties the store, clears the count and overflow flag.
module greedy_circle_suppression_top
  import gcs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [DATA_W-1:0] in_tdata,   // center_x, center_y, circle_radius, sign_kind
  input  logic              in_tlast,   // final_item
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [DATA_W-1:0] out_tdata,  // kept_x, kept_y, kept_radius, kept_kind
  output logic              out_tlast,  // end_of_set
  output logic [0:0]        out_tuser   // overflowed
);

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_OUT
  } state_t;

  state_t           state_r;
  logic [CNT_W-1:0] cnt_r;
  logic             ovf_r;
  logic [CYC_W-1:0] cyc_r;
  circle_t          pick_r, best_r;
  logic             pick_v_r, found_r;
  logic [FIELDS_W-1:0] out_data_r;
  logic             out_valid_r, out_last_r, out_user_r;

  circle_t          cells [MAX_CIRCLES];
  circle_t          new_c;
  cell_ctl_t        ctl;
  logic             in_acc, room, out_free, leave_out;
  logic             dec_v, survive, kill, better, take;
  circle_t          dec_c;

  assign in_tready = (state_r == ST_LOAD);
  assign in_acc    = in_tvalid && in_tready;
  assign room      = cnt_r < CNT_W'(MAX_CIRCLES);

  assign new_c.alive = 1'b1;
  assign new_c.idx   = cnt_r[IDX_W-1:0];
  assign new_c.x     = in_tdata[X_W-1:0];
  assign new_c.y     = in_tdata[X_W+Y_W-1:X_W];
  assign new_c.r     = in_tdata[X_W+Y_W+R_W-1:X_W+Y_W];
  assign new_c.kind  = in_tdata[FIELDS_W-1:X_W+Y_W+R_W];

  assign out_free  = !out_valid_r || out_tready;
  // Leave the hand-over state once a pending pick (if any) can go to the output register.
  assign leave_out = (state_r == ST_OUT) && (!pick_v_r || out_free);

  // Shift the ring on a stored load or on every scan cycle; empty it when a set is done.
  assign ctl.shift_en = (in_acc && room) || (state_r == ST_SCAN);
  assign ctl.clear    = leave_out && !found_r;

  for (genvar i = 0; i < MAX_CIRCLES; i++) begin : g_cell
    circle_t prev_c;
    if (i == 0) begin : g_head
      assign prev_c = (state_r == ST_LOAD) ? new_c : cells[MAX_CIRCLES-1];
    end else begin : g_body
      assign prev_c = cells[i-1];
    end
    gcs_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (ctl),
      .kill  (kill && (i == KILL_POS)),
      .prev  (prev_c),
      .cur   (cells[i])
    );
  end

  // Test each circle once per pass as it leaves the last cell.
  gcs_tester u_tester (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_v       ((state_r == ST_SCAN) && (cyc_r < CYC_W'(MAX_CIRCLES))),
    .circ       (cells[MAX_CIRCLES-1]),
    .pick       (pick_r),
    .pick_valid (pick_v_r),
    .dec_v      (dec_v),
    .dec_circ   (dec_c),
    .survive    (survive)
  );

  // Drop overlapping circles; the previous pick overlaps itself and is dropped too.
  assign kill   = dec_v && !survive;
  // Largest radius wins; on a tie the earliest loaded one.
  assign better = !found_r || (dec_c.r > best_r.r) ||
                  ((dec_c.r == best_r.r) && (dec_c.idx < best_r.idx));
  assign take   = dec_v && dec_c.alive && survive && better;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      cyc_r       <= '0;
      pick_v_r    <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // Drop the output request once taken, unless a new pick replaces it.
      if (out_valid_r && out_tready && !(leave_out && pick_v_r)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_LOAD: begin
          if (in_acc) begin
            if (room) begin
              cnt_r <= cnt_r + CNT_W'(1);
            end else begin
              ovf_r <= 1'b1;
            end
            if (in_tlast) begin
              state_r  <= ST_SCAN;
              cyc_r    <= '0;
              pick_v_r <= 1'b0;
              found_r  <= 1'b0;
            end
          end
        end
        ST_SCAN: begin
          cyc_r <= cyc_r + CYC_W'(1);
          if (take) begin
            best_r  <= dec_c;
            found_r <= 1'b1;
          end
          if (cyc_r == CYC_W'(MAX_CIRCLES + 1)) begin
            state_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (leave_out) begin
            if (pick_v_r) begin
              out_valid_r <= 1'b1;
              out_data_r  <= {pick_r.kind, pick_r.r, pick_r.y, pick_r.x};
              out_last_r  <= !found_r;
              out_user_r  <= ovf_r;
            end
            if (found_r) begin
              pick_r   <= best_r;
              pick_v_r <= 1'b1;
              found_r  <= 1'b0;
              cyc_r    <= '0;
              state_r  <= ST_SCAN;
            end else begin
              pick_v_r <= 1'b0;
              cnt_r    <= '0;
              ovf_r    <= 1'b0;
              state_r  <= ST_LOAD;
            end
          end
        end
        default: begin
          state_r <= ST_LOAD;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(DATA_W-FIELDS_W){1'b0}}, out_data_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;

  // The fill count never passes the store size.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_CIRCLES))
    else $error("fill count beyond store size");

  // A candidate that finds the store full marks the set as overflowed.
  a_ovf_set: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !room |=> ovf_r)
    else $error("overflow not flagged");

  // Emitting the last result of a set returns the block to an empty store.
  a_set_end: assert property (@(posedge clk) disable iff (!rst_n)
    leave_out && pick_v_r && !found_r |=> (cnt_r == '0) && !ovf_r && in_tready)
    else $error("set not closed after last result");

  // No item is taken while a pass is running.
  a_no_load_scan: assert property (@(posedge clk) disable iff (!rst_n)
    dec_v |-> !in_tready)
    else $error("input taken during suppression pass");

endmodule

@@ hdl/gcs_cell.sv @@
// One storage cell of the circle ring: holds a circle and passes it on.
module gcs_cell
  import gcs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cell_ctl_t ctl,
  input  logic      kill,
  input  circle_t   prev,
  output circle_t   cur
);

  circle_t cur_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r.alive <= 1'b0;
    end else if (ctl.clear) begin
      cur_r.alive <= 1'b0;
    end else if (ctl.shift_en) begin
      cur_r.alive <= prev.alive & ~kill;
      cur_r.idx   <= prev.idx;
      cur_r.kind  <= prev.kind;
      cur_r.r     <= prev.r;
      cur_r.y     <= prev.y;
      cur_r.x     <= prev.x;
    end
  end

  assign cur = cur_r;

endmodule

@@ hdl/gcs_tester.sv @@
// Two-stage overlap test of a circle against the current pick.
module gcs_tester
  import gcs_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_v,
  input  circle_t circ,
  input  circle_t pick,
  input  logic    pick_valid,
  output logic    dec_v,
  output circle_t dec_circ,
  output logic    survive
);

  logic            v1_r, v2_r;
  circle_t         c1_r, c2_r;
  logic [X_W-1:0]  dx_r;
  logic [Y_W-1:0]  dy_r;
  logic [RS_W-1:0] rs_r;
  logic [SQ_W-1:0] dx2_r, dy2_r, rs2_r;
  logic [SQ_W:0]   dist2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_v;
      v2_r <= v1_r;
    end
  end

  // Stage 1: absolute differences and radius sum.
  always_ff @(posedge clk) begin
    c1_r <= circ;
    dx_r <= (circ.x > pick.x) ? circ.x - pick.x : pick.x - circ.x;
    dy_r <= (circ.y > pick.y) ? circ.y - pick.y : pick.y - circ.y;
    rs_r <= {1'b0, circ.r} + {1'b0, pick.r};
  end

  // Stage 2: squares.
  always_ff @(posedge clk) begin
    c2_r  <= c1_r;
    dx2_r <= SQ_W'({{(SQ_W-X_W){1'b0}}, dx_r} * {{(SQ_W-X_W){1'b0}}, dx_r});
    dy2_r <= SQ_W'({{(SQ_W-Y_W){1'b0}}, dy_r} * {{(SQ_W-Y_W){1'b0}}, dy_r});
    rs2_r <= SQ_W'({{(SQ_W-RS_W){1'b0}}, rs_r} * {{(SQ_W-RS_W){1'b0}}, rs_r});
  end

  assign dist2    = {1'b0, dx2_r} + {1'b0, dy2_r};
  assign survive  = !pick_valid || (dist2 > {1'b0, rs2_r});
  assign dec_v    = v2_r;
  assign dec_circ = c2_r;

endmodule
